/* rtl/rolling_std_deviation_macros.svh */
// Assertion helpers for the rolling deviation block.
`ifndef ROLLING_STD_DEVIATION_MACROS_SVH
`define ROLLING_STD_DEVIATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RSD_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: check failed");
// Same, but the consequent is checked in the next cycle.
`define RSD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: check failed");
`endif

/* rtl/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared constants and types for the rolling standard deviation block.
// ----------------------------------------------------------------------------
package rsd_pkg;
  localparam int WindowMax = 64;
  localparam int SlotW     = $clog2(WindowMax);
  localparam int CountW    = $clog2(WindowMax + 1);
  localparam int SampleW   = 32;
  localparam int SumW      = SampleW + SlotW + 1;
  localparam int SqW       = 2 * (SampleW + 2) + SlotW;
  localparam logic [6:0] WinLenReset = 7'd20;
  localparam logic [0:0] RegWinLen   = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM_RD, S_SUM, S_DIV1, S_SQ_RD, S_SQ, S_SQ_ACC, S_DIV2, S_SQRT, S_OUT
  } rsd_state_t;

  // start/busy between sequencer and arithmetic helpers
  typedef struct packed {
    logic start;
    logic busy;
  } rsd_ctl_t;
endpackage

/* rtl/rsd_ram.sv */
// ----------------------------------------------------------------------------
// rsd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsd_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/rsd_divider.sv */
// ----------------------------------------------------------------------------
// rsd_divider
// Restoring divider, one quotient bit per cycle, numerator unsigned SqW bits,
// divisor 7 bits. Quotient saturates to 64 bits.
// ----------------------------------------------------------------------------
module rsd_divider
  import rsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rsd_ctl_t         ctl_in,
  input  logic [SqW-1:0]   num,
  input  logic [6:0]       den,
  output logic             busy,
  output logic [63:0]      quot
);
  localparam int CntW = $clog2(SqW + 1);

  logic [SqW-1:0]  q;
  logic [7:0]      r;
  logic [CntW-1:0] cnt;
  logic [7:0]      trial;

  assign trial = {r[6:0], q[SqW-1]};
  assign busy  = (cnt != '0);
  // anything above 64 bits means overflow: saturate
  assign quot  = (|q[SqW-1:64]) ? '1 : q[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl_in.start) begin
      cnt <= CntW'(SqW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      q <= num;
      r <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        r <= trial - {1'b0, den};
        q <= {q[SqW-2:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[SqW-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/rsd_sqrt.sv */
// ----------------------------------------------------------------------------
// rsd_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module rsd_sqrt
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rsd_ctl_t    ctl_in,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        run;

  assign busy = run;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (ctl_in.start) begin
      run <= 1'b1;
    end else if (run && bitv[1:0] != 2'b00) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      v    <= radicand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (run) begin
      if (v >= res + bitv) begin
        v   <= v - (res + bitv);
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule

/* rtl/rolling_std_deviation.sv */
// ----------------------------------------------------------------------------
// rolling_std_deviation
// Rolling population standard deviation over a ring of Q8.24 samples.
// ----------------------------------------------------------------------------
// channel | signals                         | direction
// input   | valid ready start_series sample | in
// output  | valid_out ready_out valid_res deviation | out
// config  | APB psel..prdata (window_len @0) | in
// Steps per transaction, n = window: a sum pass over the n newest samples,
// a squares pass, two divisions for the mean and the variance (one quotient
// bit per cycle), then the square root. A window not yet full gives valid_res low.
// The single ring RAM read port sets the pass length. No clearing pass.
// Reset is synchronous; a stalled result holds in the output register and
// blocks the next transaction until it is taken.
module rolling_std_deviation
  import rsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid,
  output logic               ready,
  input  logic               start_series,
  input  logic signed [31:0] sample,
  output logic               valid_out,
  input  logic               ready_out,
  output logic               valid_res,
  output logic [31:0]        deviation
);
  logic [6:0]        window_len;
  logic [SlotW-1:0]  write_slot;
  logic [CountW-1:0] fill_count;
  logic [6:0]        n;
  logic [SlotW:0]    k;
  logic [SlotW:0]    k_end;
  logic [SlotW-1:0]  raddr;
  logic [31:0]       rdata;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] mean;
  logic [SampleW+1:0] absd;
  logic [SqW-1:0]    acc;
  logic [2*SampleW+3:0] sq;
  rsd_state_t        state, state_next;
  rsd_ctl_t          div_ctl, sq_ctl;
  logic              div_busy, sq_busy;
  logic [63:0]       quot;
  logic [31:0]       root;
  logic              mean_pass;
  logic [SqW-1:0]    div_num;
  logic              neg;
  logic signed [SumW+1:0] dsub;
  logic [6:0]        eff_n;

  assign pready = 1'b1;
  assign prdata = (paddr == RegWinLen) ? {25'd0, window_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WinLenReset;
    end else if (psel && penable && pwrite && paddr == RegWinLen) begin
      window_len <= pwdata[6:0];
    end
  end

  assign eff_n = (window_len == 7'd0) ? 7'd1 :
                 (window_len > 7'(WindowMax)) ? 7'(WindowMax) : window_len;

  assign ready = (state == S_IDLE) && !valid_out;
  assign raddr = SlotW'(write_slot - 1'b1 - k[SlotW-1:0]);
  // read data is registered, so it lags the address: one extra step closes each pass
  assign k_end = (SlotW+1)'(n) + 1'b1;

  rsd_ram #(.Width(SampleW), .Depth(WindowMax)) u_ring (
    .clk  (clk),
    .we   (valid && ready),
    .waddr(write_slot),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  // division numerator: sum (first pass, sign handled via magnitude) or acc
  assign neg     = sum[SumW-1];
  assign div_num = mean_pass ? SqW'(neg ? -sum : sum) : acc;

  rsd_divider u_div (
    .clk(clk), .rst(rst), .ctl_in(div_ctl), .num(div_num), .den(n),
    .busy(div_busy), .quot(quot)
  );

  rsd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .ctl_in(sq_ctl), .radicand(quot),
    .busy(sq_busy), .root(root)
  );

  assign dsub = $signed({{2{rdata[31]}}, {(SumW-32){rdata[31]}}, rdata}) - mean;
  assign absd = dsub[SumW+1] ? (SampleW+2)'(-dsub) : (SampleW+2)'(dsub);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_ctl       = '0;
    sq_ctl        = '0;
    div_ctl.busy  = div_busy;
    sq_ctl.busy   = sq_busy;
    unique case (state)
      S_IDLE:   if (valid && ready) state_next = S_SUM_RD;
      S_SUM_RD: if (fill_count < CountW'(n)) begin
                  state_next = S_IDLE;
                end else begin
                  state_next = S_SUM;
                end
      S_SUM:    if (k == k_end) begin
                  div_ctl.start = 1'b1;
                  state_next = S_DIV1;
                end
      S_DIV1:   if (!div_busy && !div_ctl.start) state_next = S_SQ_RD;
      S_SQ_RD:  state_next = S_SQ;
      S_SQ:     state_next = S_SQ_ACC;
      S_SQ_ACC: if (k == k_end) begin
                  div_ctl.start = 1'b1;
                  state_next = S_DIV2;
                end else begin
                  state_next = S_SQ;
                end
      S_DIV2:   if (!div_busy) begin
                  sq_ctl.start = 1'b1;
                  state_next = S_SQRT;
                end
      S_SQRT:   if (!sq_busy && !sq_ctl.start) state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      valid_out  <= 1'b0;
    end else begin
      if (valid_out && ready_out) valid_out <= 1'b0;
      if (valid && ready) begin
        write_slot <= write_slot + 1'b1;
        if (start_series) begin
          fill_count <= CountW'(1);
        end else if (fill_count < CountW'(WindowMax)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (state == S_OUT || (state == S_SUM_RD && fill_count < CountW'(n))) begin
        valid_out <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        n         <= eff_n;
        k         <= '0;
        sum       <= '0;
        acc       <= '0;
        mean_pass <= 1'b1;
      end
      S_SUM_RD: begin
        k <= k + 1'b1;
        if (fill_count < CountW'(n)) begin
          valid_res <= 1'b0;
          deviation <= '0;
        end
      end
      S_SUM: if (k != k_end) begin
        sum <= sum + SumW'($signed(rdata));
        k   <= k + 1'b1;
      end
      S_DIV1: if (!div_busy && !div_ctl.start) begin
        // floor division of a signed sum
        mean      <= neg ? -$signed(SumW'(quot)) - SumW'(|(SqW'(-sum) - SqW'(quot) * n))
                         : $signed(SumW'(quot));
        mean_pass <= 1'b0;
        k         <= '0;
      end
      S_SQ_RD: k <= k + 1'b1;
      S_SQ:    sq <= absd * absd;
      S_SQ_ACC: if (k != k_end) begin
        acc <= acc + SqW'(sq);
        k   <= k + 1'b1;
      end
      S_OUT: begin
        valid_res <= 1'b1;
        deviation <= root;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/rsd_checker.sv */
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the rolling deviation block.
// ----------------------------------------------------------------------------
`include "rolling_std_deviation_macros.svh"
module rsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        valid_out,
  input logic        ready_out,
  input logic        valid_res,
  input logic [31:0] deviation
);
  `RSD_ASSERT_NEXT(a_out_holds, valid_out && !ready_out, valid_out && $stable(deviation))
  `RSD_ASSERT_IMPL(a_nan_zero, valid_out && !valid_res, deviation == 32'd0)
  `RSD_ASSERT_NEXT(a_no_take_busy, valid && ready, !ready)
  `RSD_ASSERT_IMPL(a_busy_out, valid_out, !ready)
endmodule

bind rolling_std_deviation rsd_checker u_rsd_checker (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .valid_out(valid_out),
  .ready_out(ready_out), .valid_res(valid_res), .deviation(deviation)
);

/* test/rsd_checker.sv */
// ----------------------------------------------------------------------------
// rsd_scoreboard
// Watches the sample, result and register ports of the rolling deviation
// block, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
module rsd_scoreboard
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        valid,
  input  logic        ready,
  input  logic        start_series,
  input  logic [31:0] sample,
  input  logic        valid_out,
  input  logic        ready_out,
  input  logic        valid_res,
  input  logic [31:0] deviation,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [31:0] dev;
  } dev_result_t;

  logic [31:0]  hist [WindowMax];
  logic [5:0]   next_slot;
  int           fill;
  logic [6:0]   win_len;
  dev_result_t  dev_expect_q[$];

  initial pending = 0;

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // newest sample sits at next_slot-1
  function automatic logic [31:0] window_deviation(int n);
    longint      sum, mean, d;
    logic [63:0] mag;
    logic [127:0] acc, q;
    logic [5:0]  idx;
    sum = 0;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      idx = next_slot - 6'd1 - 6'(k);
      sum += longint'(signed'(hist[idx]));
    end
    mean = sum / longint'(n);
    if ((sum % longint'(n)) != 0 && sum < 0) mean -= 1;
    for (int k = 0; k < n; k++) begin
      idx = next_slot - 6'd1 - 6'(k);
      d = longint'(signed'(hist[idx])) - mean;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      acc += {64'd0, mag} * {64'd0, mag};
    end
    q = acc / 128'(n);
    if (q[127:64] != 0) return floor_sqrt('1);
    return floor_sqrt(q[63:0]);
  endfunction

  always @(posedge clk) begin
    int n;
    dev_result_t e;
    if (rst) begin
      next_slot = '0;
      fill = 0;
      win_len <= WinLenReset;
      fail_count = 0;
      dev_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegWinLen)
        win_len <= pwdata[6:0];

      if (valid && ready) begin
        n = (win_len == 0) ? 1 : ((win_len > WindowMax) ? WindowMax : int'(win_len));
        if (start_series) fill = 0;
        hist[next_slot] = sample;
        next_slot = next_slot + 6'd1;
        if (fill < WindowMax) fill++;
        if (fill >= n) e = '{ok: 1'b1, dev: window_deviation(n)};
        else           e = '{ok: 1'b0, dev: 32'd0};
        dev_expect_q = {dev_expect_q, e};
      end

      if (valid_out && ready_out) begin
        if (dev_expect_q.size() == 0) begin
          $display("%0t: unexpected result transaction valid_res=%0b deviation=%h",
                   $time, valid_res, deviation);
          fail_count++;
        end else begin
          e = dev_expect_q.pop_front();
          if (valid_res !== e.ok) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.ok, valid_res);
            fail_count++;
          end
          if (deviation !== e.dev) begin
            $display("%0t: deviation expected %h actual %h", $time, e.dev, deviation);
            fail_count++;
          end
        end
      end
    end
    pending = dev_expect_q.size();
  end
endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives samples and window settings into the rolling deviation block with
// random gaps and output stalls; rsd_scoreboard predicts and checks results.
// ----------------------------------------------------------------------------
module testbench;
  import rsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid = 1'b0;
  logic        ready;
  logic        start_series = 1'b0;
  logic signed [31:0] sample = '0;
  logic        valid_out;
  logic        ready_out = 1'b0;
  logic        valid_res;
  logic [31:0] deviation;
  int          fail_count;
  int          pending;
  int          burst_left = 0;

  always #1 clk = ~clk;

  rolling_std_deviation dut (.*);

  rsd_scoreboard chk (.*);

  // receiver stall pattern: a random mode, redrawn whenever its counter runs out
  int stall_mode = 0;
  int mode_cnt = 0;
  always @(posedge clk) begin
    if (mode_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_cnt <= $urandom_range(100, 600);
    end else begin
      mode_cnt <= mode_cnt - 1;
    end
    case (stall_mode)
      0: ready_out <= 1'b1;
      1: ready_out <= ($urandom_range(0, 3) != 0);
      2: ready_out <= ($urandom_range(0, 3) == 0);
      default: ready_out <= ((mode_cnt / 40) % 2 == 0);
    endcase
  end

  task automatic write_window(logic [6:0] len);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegWinLen;
    pwdata <= {25'd0, len};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(logic ss, logic [31:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
      if (gap > 0) begin
        @(posedge clk);
        valid <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
    burst_left--;
    @(posedge clk);
    valid <= 1'b1;
    start_series <= ss;
    sample <= smp;
    do @(posedge clk); while (!ready);
    valid <= 1'b0;
  endtask

  // wait on the clock first so the last accepted transaction is already counted
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'(signed'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  initial begin
    logic [6:0] lens [7];
    lens = '{7'd20, 7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd20};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes with short window, new series mid-stream
    write_window(7'd4);
    send_sample(1'b1, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'h7FFF_FFFF);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_0001);
    send_sample(1'b0, 32'hFFFF_FFFD);
    send_sample(1'b0, 32'h0100_0000);
    send_sample(1'b0, 32'hFF00_0000);
    drain();
    write_window(7'd0);
    send_sample(1'b0, 32'h1234_5678);
    send_sample(1'b1, 32'h8000_0000);
    drain();
    write_window(7'd127);
    for (int i = 0; i < 8; i++) send_sample(i == 0, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) lens[p] = 7'($urandom_range(2, 63));
      write_window(lens[p]);
      for (int i = 0; i < 105; i++)
        send_sample(($urandom_range(0, 39) == 0) || i == 0, rand_sample());
      drain();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
